/* sv/iem_pkg.sv */
// ----------------------------------------------------------------------------
// iem_pkg
// Shared types and constants of the injected event echo matcher: ring size,
// command and register codes, and the control and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package iem_pkg;

  localparam int RING_DEPTH = 128;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int VK_W    = 8;
  localparam int SCAN_W  = 16;
  localparam int TIME_W  = 48;
  localparam int TTL_W   = 24;
  localparam int MAP_W   = 64;
  localparam int NUM_MAP = 4;
  localparam int REG_W   = 3;
  localparam int DATA_W  = 64;

  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(300000);

  typedef enum logic [1:0] {
    CMD_REC_FILT = 2'd0,
    CMD_REC_RAW  = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_code_t;

  typedef enum logic [REG_W-1:0] {
    REG_SESSION  = 3'd0,
    REG_TRACKING = 3'd1,
    REG_TTL      = 3'd2,
    REG_TEARDOWN = 3'd3,
    REG_MAP0     = 3'd4,
    REG_MAP1     = 3'd5,
    REG_MAP2     = 3'd6,
    REG_MAP3     = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic kind;
    logic [VK_W-1:0] vk;
    logic [SCAN_W-1:0] scan;
    logic ext;
    logic down;
  } entry_t;

  // datapath to controller
  typedef struct packed {
    logic push_ok;
    logic is_clear;
    logic is_query;
    logic teardown_hit;
    logic scan_needed;
    logic scan_hit;
    logic scan_done;
  } dp_status_t;

  // controller to datapath
  typedef struct packed {
    logic push;
    logic clear;
    logic load_query;
    logic scan_start;
    logic scan_step;
    logic res_load;
    logic res_value;
  } dp_cmd_t;

endpackage

/* sv/iem_ctrl.sv */
// ----------------------------------------------------------------------------
// iem_ctrl
// Controller: accepts items, steers record and clear writes, and runs the
// ring scan of a query until a hit or the end of the valid entries.
// ----------------------------------------------------------------------------
module iem_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  iem_pkg::dp_status_t st,
  output iem_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done
);
  import iem_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.push  = st.push_ok;
          cmd.clear = st.is_clear;
          if (st.is_query) begin
            cmd.load_query = 1'b1;
            if (st.teardown_hit) begin
              cmd.res_load  = 1'b1;
              cmd.res_value = 1'b1;
            end else if (!st.scan_needed) begin
              cmd.res_load  = 1'b1;
              cmd.res_value = 1'b0;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_hit) begin
          cmd.res_load  = 1'b1;
          cmd.res_value = 1'b1;
          state_next    = S_IDLE;
        end else if (st.scan_done) begin
          cmd.res_load  = 1'b1;
          cmd.res_value = 1'b0;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.res_load;
    end
  end

  a_quick_answer: assert property (@(posedge clk) disable iff (rst)
    accept && st.is_query && (st.teardown_hit || !st.scan_needed) |=> done && !busy)
    else $error("quick query answer missing");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && (st.scan_hit || st.scan_done) |=> done && !busy)
    else $error("scan end did not report");

  a_no_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.push && !cmd.clear && !cmd.load_query)
    else $error("ring change while a scan runs");

endmodule

/* sv/iem_datapath.sv */
// ----------------------------------------------------------------------------
// iem_datapath
// Datapath: configuration registers, ring memory of entries and stamps,
// write pointer and fill count, query latch, scan read pointer and the
// entry compare.
// ----------------------------------------------------------------------------
module iem_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [iem_pkg::REG_W-1:0]    wr_index,
  input  logic [iem_pkg::DATA_W-1:0]   wr_data,
  input  logic [1:0]                   command,
  input  logic                         kind,
  input  logic [iem_pkg::VK_W-1:0]     vk,
  input  logic [iem_pkg::SCAN_W-1:0]   scan_code,
  input  logic                         extended,
  input  logic                         is_down,
  input  logic [iem_pkg::TIME_W-1:0]   now_us,
  input  iem_pkg::dp_cmd_t             cmd,
  output iem_pkg::dp_status_t          st,
  output logic                         matched
);
  import iem_pkg::*;

  // configuration
  logic                          session_active;
  logic                          tracking_enabled;
  logic [TTL_W-1:0]              entry_ttl_us;
  logic [TIME_W-1:0]             teardown_until_us;
  logic [NUM_MAP-1:0][MAP_W-1:0] watched_map;

  // ring
  logic [$bits(entry_t)+TIME_W-1:0] ring_mem [RING_DEPTH];
  logic [PTR_W-1:0]                 write_pointer;
  logic [CNT_W-1:0]                 fill_count;

  // query and scan
  entry_t            q_entry;
  logic [TIME_W-1:0] q_now;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  scan_idx;
  logic              rd_valid;
  entry_t            rd_entry;
  logic [TIME_W-1:0] rd_stamp;

  cmd_code_t         code;
  logic              watched;
  entry_t            new_entry;
  logic [PTR_W-1:0]  wp_prev;
  logic [TIME_W-1:0] age;
  logic              live;
  logic              key_hit;
  logic              entry_hit;

  assign code = cmd_code_t'(command);

  always_ff @(posedge clk) begin
    if (rst) begin
      session_active    <= 1'b0;
      tracking_enabled  <= 1'b0;
      entry_ttl_us      <= TTL_RESET;
      teardown_until_us <= '0;
      watched_map       <= '0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_SESSION:  session_active    <= wr_data[0];
        REG_TRACKING: tracking_enabled  <= wr_data[0];
        REG_TTL:      entry_ttl_us      <= wr_data[TTL_W-1:0];
        REG_TEARDOWN: teardown_until_us <= wr_data[TIME_W-1:0];
        REG_MAP0:     watched_map[0]    <= wr_data[MAP_W-1:0];
        REG_MAP1:     watched_map[1]    <= wr_data[MAP_W-1:0];
        REG_MAP2:     watched_map[2]    <= wr_data[MAP_W-1:0];
        REG_MAP3:     watched_map[3]    <= wr_data[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign watched = (vk != '0) && watched_map[vk[7:6]][vk[5:0]];

  // buttons store no scan or extended flag; raw records are always keys
  always_comb begin
    new_entry.kind = (code == CMD_REC_FILT) && kind;
    new_entry.vk   = vk;
    new_entry.scan = new_entry.kind ? '0 : scan_code;
    new_entry.ext  = new_entry.kind ? 1'b0 : extended;
    new_entry.down = is_down;
  end

  assign st.push_ok = session_active &&
    (((code == CMD_REC_FILT) && (tracking_enabled || watched)) ||
     ((code == CMD_REC_RAW) && ((vk != '0) || (scan_code != '0))));
  assign st.is_clear     = (code == CMD_CLEAR);
  assign st.is_query     = (code == CMD_QUERY);
  assign st.teardown_hit = (teardown_until_us != '0) && (now_us <= teardown_until_us);
  assign st.scan_needed  = session_active && (fill_count != '0);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring_mem[write_pointer] <= {new_entry, now_us};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      fill_count    <= '0;
    end else if (cmd.clear) begin
      write_pointer <= '0;
      fill_count    <= '0;
    end else if (cmd.push) begin
      write_pointer <= (write_pointer == PTR_W'(RING_DEPTH - 1)) ? '0 : write_pointer + 1'b1;
      if (fill_count != CNT_W'(RING_DEPTH)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_entry.kind <= kind;
      q_entry.vk   <= vk;
      q_entry.scan <= kind ? '0 : scan_code;
      q_entry.ext  <= kind ? 1'b0 : extended;
      q_entry.down <= is_down;
      q_now        <= now_us;
    end
  end

  assign wp_prev = (write_pointer == '0) ? PTR_W'(RING_DEPTH - 1) : write_pointer - 1'b1;

  // newest entry first, one read a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      scan_idx <= '0;
      rd_ptr   <= '0;
    end else if (cmd.scan_start) begin
      rd_valid <= 1'b0;
      scan_idx <= '0;
      rd_ptr   <= wp_prev;
    end else if (cmd.scan_step) begin
      if (scan_idx != fill_count) begin
        rd_valid <= 1'b1;
        scan_idx <= scan_idx + 1'b1;
        rd_ptr   <= (rd_ptr == '0) ? PTR_W'(RING_DEPTH - 1) : rd_ptr - 1'b1;
      end else begin
        rd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && (scan_idx != fill_count)) begin
      {rd_entry, rd_stamp} <= ring_mem[rd_ptr];
    end
  end

  // future stamps count as unexpired
  assign age  = q_now - rd_stamp;
  assign live = (q_now < rd_stamp) || (age <= {{(TIME_W-TTL_W){1'b0}}, entry_ttl_us});

  assign key_hit = ((q_entry.vk != '0) && (rd_entry.vk == q_entry.vk)) ||
                   ((q_entry.scan != '0) && (rd_entry.scan == q_entry.scan) &&
                    (rd_entry.ext == q_entry.ext));

  assign entry_hit = (rd_entry.kind == q_entry.kind) && live &&
                     (rd_entry.down == q_entry.down) &&
                     (q_entry.kind ? (rd_entry.vk == q_entry.vk) : key_hit);

  assign st.scan_hit  = rd_valid && entry_hit;
  assign st.scan_done = !rd_valid && (scan_idx == fill_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      matched <= 1'b0;
    end else if (cmd.res_load) begin
      matched <= cmd.res_value;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(RING_DEPTH))
    else $error("fill count beyond ring depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> fill_count == '0 && write_pointer == '0)
    else $error("clear left entries");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> scan_idx <= fill_count)
    else $error("scan ran past the valid entries");

endmodule

/* sv/injected_event_echo_matcher.sv */
// ----------------------------------------------------------------------------
// injected_event_echo_matcher
// Keeps a ring of recently injected key and button events with timestamps
// and answers whether an observed event is the echo of one of them.
//
// An item is taken when start is high and busy is low. command selects a
// filtered record, a raw key record, a query or a ring clear; the event
// fields and now_us travel with it. Records and clears give no result. A query
// gives one result: matched is valid for the single cycle in which done is high,
// and the receiver has no way to hold it. A query answered by the teardown
// window, by an inactive session or by an empty ring shows done in the cycle
// after it is taken. Otherwise the ring is read newest first, one entry a cycle
// through the memory read port, and done shows once the last valid entry has
// been compared, earlier on a hit; busy stays high for that scan. The next item
// may be taken in the cycle that done shows.
// Configuration is written through wr_en, wr_index and wr_data at any edge
// with wr_en high. Reset empties the ring and loads the register defaults
// (entry lifetime 300000 us, everything else zero); no clearing pass.
// ----------------------------------------------------------------------------
module injected_event_echo_matcher (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command,
  input  logic                       kind,
  input  logic [iem_pkg::VK_W-1:0]   vk,
  input  logic [iem_pkg::SCAN_W-1:0] scan_code,
  input  logic                       extended,
  input  logic                       is_down,
  input  logic [iem_pkg::TIME_W-1:0] now_us,
  output logic                       done,
  output logic                       matched,
  input  logic                       wr_en,
  input  logic [iem_pkg::REG_W-1:0]  wr_index,
  input  logic [iem_pkg::DATA_W-1:0] wr_data
);
  import iem_pkg::*;

  dp_status_t st;
  dp_cmd_t    cmd;

  iem_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  iem_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .command   (command),
    .kind      (kind),
    .vk        (vk),
    .scan_code (scan_code),
    .extended  (extended),
    .is_down   (is_down),
    .now_us    (now_us),
    .cmd       (cmd),
    .st        (st),
    .matched   (matched)
  );

endmodule

/* tb/iem_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iem_checker
// Watches the item, result and register ports of the echo matcher. Keeps its
// own copy of the event ring and of the registers, works out the matched
// answer of every accepted query, and compares each done pulse in order.
// ----------------------------------------------------------------------------
module iem_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 command,
  input  logic                       kind,
  input  logic [iem_pkg::VK_W-1:0]   vk,
  input  logic [iem_pkg::SCAN_W-1:0] scan_code,
  input  logic                       extended,
  input  logic                       is_down,
  input  logic [iem_pkg::TIME_W-1:0] now_us,
  input  logic                       done,
  input  logic                       matched,
  input  logic                       wr_en,
  input  logic [iem_pkg::REG_W-1:0]  wr_index,
  input  logic [iem_pkg::DATA_W-1:0] wr_data,
  output int                         mismatches,
  output int                         answers_due
);
  import iem_pkg::*;

  entry_t            ring_fields [RING_DEPTH];
  logic [TIME_W-1:0] ring_stamps [RING_DEPTH];
  logic [PTR_W-1:0]  ring_head;
  int unsigned       ring_fill;

  logic              sess_on;
  logic              track_all;
  logic [TTL_W-1:0]  ttl_us;
  logic [TIME_W-1:0] teardown_us;
  logic [MAP_W-1:0]  watch_map [NUM_MAP];

  bit                echo_answers [$];
  bit                want;
  entry_t            incoming;

  task automatic store_event(input entry_t e, input logic [TIME_W-1:0] t);
    ring_fields[ring_head] = e;
    ring_stamps[ring_head] = t;
    ring_head = ring_head + 1'b1;
    if (ring_fill < RING_DEPTH) ring_fill++;
  endtask

  // newest entry first; a stamp later than t never expires
  function automatic bit ring_has_echo(input logic k, input logic [VK_W-1:0] v,
                                       input logic [SCAN_W-1:0] sc, input logic x,
                                       input logic d, input logic [TIME_W-1:0] t);
    int unsigned       i;
    logic [PTR_W-1:0]  slot;
    entry_t            e;
    logic [TIME_W-1:0] st;
    bit                hit;
    hit = 1'b0;
    for (i = 0; i < ring_fill && !hit; i++) begin
      slot = PTR_W'((ring_head + RING_DEPTH - 1 - i) % RING_DEPTH);
      e = ring_fields[slot];
      st = ring_stamps[slot];
      if (e.kind == k && !(t >= st && (t - st) > ttl_us) && e.down == d) begin
        if (k) begin
          hit = (e.vk == v);
        end else begin
          hit = (v != 0 && e.vk == v) || (sc != 0 && e.scan == sc && e.ext == x);
        end
      end
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ring_head = '0;
      ring_fill = 0;
      sess_on = 1'b0;
      track_all = 1'b0;
      ttl_us = TTL_RESET;
      teardown_us = '0;
      watch_map = '{default: '0};
      echo_answers.delete();
      mismatches = 0;
    end else begin
      if (done) begin
        if (echo_answers.size() == 0) begin
          if (mismatches < 10)
            $display("iem_checker: %0t result matched=%0b with no query outstanding",
                     $realtime, matched);
          mismatches++;
        end else begin
          want = echo_answers.pop_front();
          if (matched !== want) begin
            if (mismatches < 10)
              $display("iem_checker: %0t matched expected %0b got %0b",
                       $realtime, want, matched);
            mismatches++;
          end
        end
      end

      if (wr_en) begin
        case (wr_index)
          REG_SESSION:  sess_on = wr_data[0];
          REG_TRACKING: track_all = wr_data[0];
          REG_TTL:      ttl_us = wr_data[TTL_W-1:0];
          REG_TEARDOWN: teardown_us = wr_data[TIME_W-1:0];
          REG_MAP0:     watch_map[0] = wr_data;
          REG_MAP1:     watch_map[1] = wr_data;
          REG_MAP2:     watch_map[2] = wr_data;
          REG_MAP3:     watch_map[3] = wr_data;
          default: ;
        endcase
      end

      if (start && !busy) begin
        incoming.kind = 1'b0;
        incoming.vk = vk;
        incoming.scan = scan_code;
        incoming.ext = extended;
        incoming.down = is_down;
        case (command)
          CMD_REC_FILT: begin
            if (sess_on && (track_all || (vk != 0 && watch_map[vk[7:6]][vk[5:0]]))) begin
              // buttons keep no scan code or extended flag
              if (kind) begin
                incoming.kind = 1'b1;
                incoming.scan = '0;
                incoming.ext = 1'b0;
              end
              store_event(incoming, now_us);
            end
          end
          CMD_REC_RAW: begin
            if (sess_on && (vk != 0 || scan_code != 0)) store_event(incoming, now_us);
          end
          CMD_QUERY: begin
            if (teardown_us != 0 && now_us <= teardown_us) want = 1'b1;
            else if (!sess_on) want = 1'b0;
            else want = ring_has_echo(kind, vk, scan_code, extended, is_down, now_us);
            echo_answers.insert(echo_answers.size(), want);
          end
          CMD_CLEAR: begin
            ring_head = '0;
            ring_fill = 0;
          end
          default: ;
        endcase
      end
    end
    answers_due = echo_answers.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the echo matcher with a directed set of records and queries, then
// with random phases under several register settings, in bursts with random
// gaps. The checker beside the block predicts every query answer.
// ----------------------------------------------------------------------------
module tb_top;
  import iem_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    cmd_code_t         cmd;
    logic              kind;
    logic [VK_W-1:0]   vk;
    logic [SCAN_W-1:0] scan;
    logic              ext;
    logic              down;
    logic [TIME_W-1:0] now;
  } ev_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        command = '0;
  logic              kind = 1'b0;
  logic [VK_W-1:0]   vk = '0;
  logic [SCAN_W-1:0] scan_code = '0;
  logic              extended = 1'b0;
  logic              is_down = 1'b0;
  logic [TIME_W-1:0] now_us = '0;
  logic              wr_en = 1'b0;
  logic [REG_W-1:0]  wr_index = '0;
  logic [DATA_W-1:0] wr_data = '0;
  logic              busy;
  logic              done;
  logic              matched;
  int                mismatches;
  int                answers_due;

  logic [TIME_W-1:0] t_now = 48'd10000;
  ev_item_t          recent [8];
  logic [2:0]        recent_wr = '0;
  int unsigned       recent_n = 0;
  int unsigned       burst_left = 0;

  always #4 clk = ~clk;

  injected_event_echo_matcher DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .kind(kind), .vk(vk), .scan_code(scan_code), .extended(extended),
    .is_down(is_down), .now_us(now_us), .done(done), .matched(matched),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  iem_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .kind(kind), .vk(vk), .scan_code(scan_code), .extended(extended),
    .is_down(is_down), .now_us(now_us), .done(done), .matched(matched),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .mismatches(mismatches), .answers_due(answers_due)
  );

  function automatic ev_item_t item_of(input cmd_code_t c, input logic k,
                                       input logic [VK_W-1:0] v,
                                       input logic [SCAN_W-1:0] sc, input logic x,
                                       input logic d, input logic [TIME_W-1:0] t);
    ev_item_t it;
    it.cmd = c;
    it.kind = k;
    it.vk = v;
    it.scan = sc;
    it.ext = x;
    it.down = d;
    it.now = t;
    return it;
  endfunction

  // mostly records followed by queries of the same events, some noise
  function automatic ev_item_t next_item(input int unsigned clear_pct);
    ev_item_t    it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) t_now = t_now + $urandom_range(0, 400000);
    else t_now = t_now + $urandom_range(0, 3000);
    it = item_of(CMD_QUERY, 1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), t_now);
    if (roll < clear_pct) begin
      it.cmd = CMD_CLEAR;
    end else if (roll < 50) begin
      it.cmd = $urandom_range(0, 1) ? CMD_REC_FILT : CMD_REC_RAW;
      if ($urandom_range(0, 1)) it.vk = 8'($urandom_range(0, 7));
      if ($urandom_range(0, 1)) it.scan = 16'($urandom_range(0, 7));
      recent[recent_wr] = it;
      recent_wr = recent_wr + 3'd1;
      if (recent_n < 8) recent_n++;
    end else if (roll < 85 && recent_n > 0) begin
      it = recent[3'($urandom_range(0, recent_n - 1))];
      it.cmd = CMD_QUERY;
      it.now = t_now;
      case ($urandom_range(0, 9))
        0: it.down = ~it.down;
        1: it.ext = ~it.ext;
        2: it.vk = '0;
        3: it.scan = '0;
        4: it.kind = ~it.kind;
        5: it.now = t_now - $urandom_range(1, 5000);
        default: ;
      endcase
    end else if (roll < 92) begin
      it.cmd = cmd_code_t'($urandom_range(0, 3));
      it.now = {16'($urandom), 32'($urandom)};
    end
    return it;
  endfunction

  task automatic send_item(input ev_item_t it);
    start <= 1'b1;
    command <= it.cmd;
    kind <= it.kind;
    vk <= it.vk;
    scan_code <= it.scan;
    extended <= it.ext;
    is_down <= it.down;
    now_us <= it.now;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic run_random(input int n, input int unsigned clear_pct);
    repeat (n) send_item(next_item(clear_pct));
  endtask

  // stop sending and wait for every answer and for the block to go quiet
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (answers_due != 0 || busy) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input reg_index_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
  endtask

  task automatic configure(input logic s, input logic tr, input logic [TTL_W-1:0] ttl,
                           input logic [TIME_W-1:0] td, input logic [MAP_W-1:0] m0,
                           input logic [MAP_W-1:0] m1, input logic [MAP_W-1:0] m2,
                           input logic [MAP_W-1:0] m3);
    set_reg(REG_SESSION, {63'd0, s});
    set_reg(REG_TRACKING, {63'd0, tr});
    set_reg(REG_TTL, {40'd0, ttl});
    set_reg(REG_TEARDOWN, {16'd0, td});
    set_reg(REG_MAP0, m0);
    set_reg(REG_MAP1, m1);
    set_reg(REG_MAP2, m2);
    set_reg(REG_MAP3, m3);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: session off, so nothing is recorded
    send_item(item_of(CMD_REC_FILT, 1'b0, 8'h41, 16'h001E, 1'b0, 1'b1, 48'd500));
    send_item(item_of(CMD_REC_RAW, 1'b0, 8'h41, 16'h001E, 1'b0, 1'b1, 48'd500));
    send_item(item_of(CMD_QUERY, 1'b0, 8'h41, 16'h001E, 1'b0, 1'b1, 48'd600));
    drain_results();

    configure(1'b1, 1'b0, 24'd300000, '0, 64'h3, 64'h2, 64'h0, 64'h8000_0000_0000_0000);
    // code 0 is never watched even with its bit set
    send_item(item_of(CMD_REC_FILT, 1'b0, 8'h00, 16'h0033, 1'b0, 1'b1, 48'd1000));
    send_item(item_of(CMD_QUERY, 1'b0, 8'h00, 16'h0033, 1'b0, 1'b1, 48'd1000));
    send_item(item_of(CMD_REC_FILT, 1'b0, 8'h41, 16'h001E, 1'b0, 1'b1, 48'd1000));
    send_item(item_of(CMD_REC_FILT, 1'b0, 8'h42, 16'h0030, 1'b0, 1'b1, 48'd1000));
    send_item(item_of(CMD_QUERY, 1'b0, 8'h41, 16'h0000, 1'b0, 1'b1, 48'd2000));
    send_item(item_of(CMD_QUERY, 1'b0, 8'h41, 16'h0000, 1'b0, 1'b0, 48'd2000));
    send_item(item_of(CMD_QUERY, 1'b0, 8'h00, 16'h001E, 1'b0, 1'b1, 48'd2000));
    send_item(item_of(CMD_QUERY, 1'b0, 8'h00, 16'h001E, 1'b1, 1'b1, 48'd2000));
    send_item(item_of(CMD_QUERY, 1'b0, 8'h42, 16'h0000, 1'b0, 1'b1, 48'd2000));
    // button record drops scan and extended flag
    send_item(item_of(CMD_REC_FILT, 1'b1, 8'h01, 16'hFFFF, 1'b1, 1'b1, 48'd3000));
    send_item(item_of(CMD_QUERY, 1'b1, 8'h01, 16'h1234, 1'b0, 1'b1, 48'd3000));
    send_item(item_of(CMD_QUERY, 1'b0, 8'h00, 16'hFFFF, 1'b1, 1'b1, 48'd3000));
    // raw record: zero code and scan dropped, kind forced to key
    send_item(item_of(CMD_REC_RAW, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b1, 48'd4000));
    send_item(item_of(CMD_REC_RAW, 1'b1, 8'hFF, 16'hFFFF, 1'b1, 1'b0, 48'd4000));
    send_item(item_of(CMD_QUERY, 1'b0, 8'hFF, 16'h0000, 1'b0, 1'b0, 48'd4000));
    send_item(item_of(CMD_QUERY, 1'b1, 8'hFF, 16'h0000, 1'b0, 1'b0, 48'd4000));
    // age exactly at the lifetime, then one past it
    send_item(item_of(CMD_QUERY, 1'b0, 8'h41, 16'h0000, 1'b0, 1'b1, 48'd301000));
    send_item(item_of(CMD_QUERY, 1'b0, 8'h41, 16'h0000, 1'b0, 1'b1, 48'd301001));
    // stamp in the future of the query
    send_item(item_of(CMD_QUERY, 1'b0, 8'hFF, 16'h0000, 1'b0, 1'b0, 48'd500));
    send_item(item_of(CMD_QUERY, 1'b0, 8'hFF, 16'hFFFF, 1'b1, 1'b0, TIME_MAX));
    send_item(item_of(CMD_CLEAR, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0, 48'd4000));
    send_item(item_of(CMD_QUERY, 1'b0, 8'hFF, 16'h0000, 1'b0, 1'b0, 48'd4000));
    drain_results();

    // teardown window wins over an inactive session
    configure(1'b0, 1'b1, 24'd0, TIME_MAX, '1, '1, '1, '1);
    send_item(item_of(CMD_QUERY, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0, 48'd0));
    drain_results();

    configure(1'b1, 1'b1, 24'd300000, '0, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    run_random(80, 3);
    drain_results();

    configure(1'b1, 1'b0, 24'hFFFFFF, '0, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    run_random(50, 3);
    drain_results();
    run_random(50, 3);
    drain_results();

    configure(1'b1, 1'b1, 24'd0, '0, '0, '0, '0, '0);
    run_random(60, 3);
    drain_results();

    configure(1'b1, 1'($urandom_range(0, 1)), 24'($urandom), t_now + 48'd2000000,
              {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom});
    run_random(80, 3);
    drain_results();

    configure(1'b0, 1'b1, 24'd300000, '0, '1, '1, '1, '1);
    run_random(30, 3);
    drain_results();

    configure(1'b1, 1'b1, 24'd300000, TIME_MAX, '1, '1, '1, '1);
    run_random(20, 3);
    drain_results();

    // long run with clears only from the random noise items, so the ring can wrap
    configure(1'b1, 1'b1, 24'hFFFFFF, '0, '1, '1, '1, '1);
    run_random(280, 0);
    drain_results();

    // time runs across the top of its range
    t_now = TIME_MAX - 48'd3000000;
    configure(1'b1, 1'b0, 24'($urandom), '0, '1, '0, '1, {$urandom, $urandom});
    run_random(60, 3);
    drain_results();

    repeat (RING_DEPTH + 4) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && answers_due == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
